[hdl/cppe_pkg.sv]
// Shared types, constants and helpers for the column post picture encoder.
package cppe_pkg;

    // Field widths
    localparam int unsigned PIX_W  = 8;
    localparam int unsigned DIM_W  = 9;
    localparam int unsigned OFS_W  = 16;
    localparam int unsigned ADDR_W = 20;
    localparam int unsigned LEN_W  = 8;

    // Default limits
    localparam int unsigned DEF_MAX_WIDTH  = 256;
    localparam int unsigned DEF_MAX_HEIGHT = 256;
    localparam int unsigned DEF_MAX_RUN    = 254;

    // Header is 8 bytes, offset entries follow
    localparam int unsigned HDR_BYTES = 8;
    localparam logic [PIX_W-1:0] COL_END_BYTE = 8'hff;

    // Configuration port
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LEFT   = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

    localparam int unsigned QUEUE_DEPTH = 2;

    // Write slots of one item, in output order. Header slots equal their address.
    localparam int unsigned NUM_PH = 21;
    localparam int unsigned PH_W   = 5;
    localparam logic [PH_W-1:0] PH_W_LO      = 5'd0;
    localparam logic [PH_W-1:0] PH_W_HI      = 5'd1;
    localparam logic [PH_W-1:0] PH_H_LO      = 5'd2;
    localparam logic [PH_W-1:0] PH_H_HI      = 5'd3;
    localparam logic [PH_W-1:0] PH_L_LO      = 5'd4;
    localparam logic [PH_W-1:0] PH_L_HI      = 5'd5;
    localparam logic [PH_W-1:0] PH_T_LO      = 5'd6;
    localparam logic [PH_W-1:0] PH_T_HI      = 5'd7;
    localparam logic [PH_W-1:0] PH_OFF_B0    = 5'd8;
    localparam logic [PH_W-1:0] PH_OFF_B1    = 5'd9;
    localparam logic [PH_W-1:0] PH_OFF_B2    = 5'd10;
    localparam logic [PH_W-1:0] PH_OFF_B3    = 5'd11;
    localparam logic [PH_W-1:0] PH_C1_POS    = 5'd12;
    localparam logic [PH_W-1:0] PH_C1_LEN    = 5'd13;
    localparam logic [PH_W-1:0] PH_PIX       = 5'd14;
    localparam logic [PH_W-1:0] PH_OPEN_ROW  = 5'd15;
    localparam logic [PH_W-1:0] PH_OPEN_PX0  = 5'd16;
    localparam logic [PH_W-1:0] PH_OPEN_PX1  = 5'd17;
    localparam logic [PH_W-1:0] PH_C2_POS    = 5'd18;
    localparam logic [PH_W-1:0] PH_C2_LEN    = 5'd19;
    localparam logic [PH_W-1:0] PH_COL_END   = 5'd20;

    typedef struct packed {
        logic [DIM_W-1:0]        width;   // clamped
        logic [DIM_W-1:0]        height;  // clamped
        logic signed [OFS_W-1:0] left;
        logic signed [OFS_W-1:0] top;
    } cfg_t;

    // One classified item, handed from the front to the back
    typedef struct packed {
        logic [NUM_PH-1:0] ph_en;
        logic [ADDR_W-1:0] wp_base;
        logic [DIM_W-1:0]  col;
        logic [ADDR_W-1:0] c1_slot;
        logic [LEN_W-1:0]  c1_len;
        logic [PIX_W-1:0]  c1_val;
        logic [PIX_W-1:0]  px;
        logic [PIX_W-1:0]  row_lo;
        logic [ADDR_W-1:0] c2_slot;
        logic [LEN_W-1:0]  c2_len;
        logic              done;
        logic [ADDR_W-1:0] lump;
    } desc_t;

    function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int unsigned maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (int'(v) > int'(maxv)) begin
            r = DIM_W'(maxv);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [PH_W-1:0] low_index(logic [NUM_PH-1:0] v);
        logic [PH_W-1:0] idx;
        idx = '0;
        for (int i = NUM_PH - 1; i >= 0; i--) begin
            if (v[i]) idx = PH_W'(i);
        end
        return idx;
    endfunction

endpackage

[hdl/cppe_regs.sv]
// Configuration registers behind the APB-style port.
module cppe_regs #(
    parameter int unsigned MAX_WIDTH  = cppe_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = cppe_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cppe_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cppe_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cppe_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output cppe_pkg::cfg_t                  cfg
);

    logic [cppe_pkg::DIM_W-1:0] width_reg, width_next;
    logic [cppe_pkg::DIM_W-1:0] height_reg, height_next;
    logic [cppe_pkg::OFS_W-1:0] left_reg, left_next;
    logic [cppe_pkg::OFS_W-1:0] top_reg, top_next;
    logic                       wr_en;
    logic [1:0]                 idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = paddr[3:2];

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        left_next   = left_reg;
        top_next    = top_reg;
        if (wr_en) begin
            unique case (idx)
                cppe_pkg::REG_WIDTH:  width_next  = pwdata[cppe_pkg::DIM_W-1:0];
                cppe_pkg::REG_HEIGHT: height_next = pwdata[cppe_pkg::DIM_W-1:0];
                cppe_pkg::REG_LEFT:   left_next   = pwdata[cppe_pkg::OFS_W-1:0];
                cppe_pkg::REG_TOP:    top_next    = pwdata[cppe_pkg::OFS_W-1:0];
                default:              width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= cppe_pkg::DIM_W'(1);
            height_reg <= cppe_pkg::DIM_W'(1);
            left_reg   <= '0;
            top_reg    <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            left_reg   <= left_next;
            top_reg    <= top_next;
        end
    end

    always_comb begin
        unique case (idx)
            cppe_pkg::REG_WIDTH:  prdata = cppe_pkg::APB_DATA_W'(width_reg);
            cppe_pkg::REG_HEIGHT: prdata = cppe_pkg::APB_DATA_W'(height_reg);
            cppe_pkg::REG_LEFT:   prdata = cppe_pkg::APB_DATA_W'(left_reg);
            cppe_pkg::REG_TOP:    prdata = cppe_pkg::APB_DATA_W'(top_reg);
            default:              prdata = '0;
        endcase
    end

    assign cfg.width  = cppe_pkg::clamp_dim(width_reg, MAX_WIDTH);
    assign cfg.height = cppe_pkg::clamp_dim(height_reg, MAX_HEIGHT);
    assign cfg.left   = left_reg;
    assign cfg.top    = top_reg;

endmodule

[hdl/cppe_front.sv]
// Front end: accepts pixels, tracks picture and run state, builds one write list per item.
module cppe_front #(
    parameter int unsigned MAX_RUN = cppe_pkg::DEF_MAX_RUN
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cppe_pkg::cfg_t             cfg,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [cppe_pkg::PIX_W-1:0] s_tdata,  // [7:0] pixel_value
    input  logic                       s_tuser,  // [0] opaque
    input  logic                       q_full,
    output logic                       q_push,
    output cppe_pkg::desc_t            q_wdata
);

    localparam int unsigned AW = cppe_pkg::ADDR_W;
    localparam int unsigned DW = cppe_pkg::DIM_W;

    logic [DW-1:0]              row_reg, row_next;
    logic [DW-1:0]              col_reg, col_next;
    logic [AW-1:0]              wp_reg, wp_next;
    logic                       act_reg, act_next;
    logic [cppe_pkg::LEN_W-1:0] len_reg, len_next;
    logic [AW-1:0]              slot_reg, slot_next;
    logic [cppe_pkg::PIX_W-1:0] lastv_reg, lastv_next;

    logic                       accept, op, first, c1, pix, open_run, colend, c2, done;
    logic [AW-1:0]              wp0, slot_mid;
    logic [cppe_pkg::LEN_W-1:0] len_mid;
    logic [2:0]                 adv;
    logic [cppe_pkg::NUM_PH-1:0] en;

    assign s_tready = !q_full;
    assign accept   = s_tvalid & s_tready;
    assign op       = s_tuser;

    always_comb begin
        first    = (row_reg == '0) && (col_reg == '0);
        wp0      = first ? (AW'({cfg.width, 2'b00}) + AW'(cppe_pkg::HDR_BYTES)) : wp_reg;
        // a full run closes before the opaque pixel, any run closes on a transparent one
        c1       = act_reg && (!op || (len_reg >= cppe_pkg::LEN_W'(MAX_RUN)));
        pix      = op && act_reg && !c1;
        open_run = op && !pix;
        len_mid  = pix ? (len_reg + 1'b1) : (open_run ? cppe_pkg::LEN_W'(1) : '0);
        slot_mid = open_run ? (wp0 + AW'(c1) + AW'(1)) : slot_reg;
        colend   = ({1'b0, row_reg} + 1'b1) >= {1'b0, cfg.height};
        c2       = colend && op;
        done     = colend && (({1'b0, col_reg} + 1'b1) >= {1'b0, cfg.width});
        adv      = 3'(c1) + 3'(pix) + (open_run ? 3'd4 : 3'd0) + 3'(c2) + 3'(colend);

        en = '0;
        if (first) begin
            en[cppe_pkg::PH_T_HI:cppe_pkg::PH_W_LO] = '1;
        end
        if (row_reg == '0) begin
            en[cppe_pkg::PH_OFF_B3:cppe_pkg::PH_OFF_B0] = '1;
        end
        en[cppe_pkg::PH_C1_POS]   = c1;
        en[cppe_pkg::PH_C1_LEN]   = c1;
        en[cppe_pkg::PH_PIX]      = pix;
        en[cppe_pkg::PH_OPEN_ROW] = open_run;
        en[cppe_pkg::PH_OPEN_PX0] = open_run;
        en[cppe_pkg::PH_OPEN_PX1] = open_run;
        en[cppe_pkg::PH_C2_POS]   = c2;
        en[cppe_pkg::PH_C2_LEN]   = c2;
        en[cppe_pkg::PH_COL_END]  = colend;

        wp_next    = wp0 + AW'(adv);
        act_next   = op && !colend;
        len_next   = colend ? '0 : len_mid;
        slot_next  = slot_mid;
        lastv_next = op ? s_tdata : lastv_reg;
        if (colend) begin
            row_next = '0;
            col_next = done ? '0 : (col_reg + 1'b1);
        end else begin
            row_next = row_reg + 1'b1;
            col_next = col_reg;
        end
    end

    always_comb begin
        q_wdata.ph_en   = en;
        q_wdata.wp_base = wp0;
        q_wdata.col     = col_reg;
        q_wdata.c1_slot = slot_reg;
        q_wdata.c1_len  = len_reg;
        q_wdata.c1_val  = lastv_reg;
        q_wdata.px      = s_tdata;
        q_wdata.row_lo  = row_reg[cppe_pkg::PIX_W-1:0];
        q_wdata.c2_slot = slot_mid;
        q_wdata.c2_len  = len_mid;
        q_wdata.done    = done;
        q_wdata.lump    = wp_next;
    end

    // items that cause no write never enter the queue
    assign q_push = accept && (en != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= '0;
            col_reg   <= '0;
            wp_reg    <= '0;
            act_reg   <= 1'b0;
            len_reg   <= '0;
            slot_reg  <= '0;
            lastv_reg <= '0;
        end else if (accept) begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            wp_reg    <= wp_next;
            act_reg   <= act_next;
            len_reg   <= len_next;
            slot_reg  <= slot_next;
            lastv_reg <= lastv_next;
        end
    end

endmodule

[hdl/cppe_queue.sv]
// Short queue of write lists between front and back.
module cppe_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  cppe_pkg::desc_t wdata,
    output logic            full,
    input  logic            pop,
    output logic            rvalid,
    output cppe_pkg::desc_t rdata
);

    localparam int unsigned DEPTH = cppe_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cppe_pkg::desc_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign rvalid  = (cnt_reg != '0);
    assign rdata   = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && rvalid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : (wr_ptr_reg + 1'b1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : (rd_ptr_reg + 1'b1);
        end
        cnt_next = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[hdl/cppe_back.sv]
// Back end: walks one write list, one byte write per cycle unless the output stalls, into the output register.
module cppe_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cppe_pkg::cfg_t              cfg,
    input  logic                        q_valid,
    input  cppe_pkg::desc_t             q_rdata,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [47:0]                 m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser
);

    localparam int unsigned AW = cppe_pkg::ADDR_W;

    cppe_pkg::desc_t             cur_reg;
    logic [cppe_pkg::NUM_PH-1:0] rem_reg, rem_next, rem_after;
    logic                        busy, out_free, emit, last, take;
    logic [cppe_pkg::PH_W-1:0]   ph;
    logic [AW-1:0]               slot_base, base, addr;
    logic [2:0]                  ofs, c1_o, run_o, end_o;
    logic [cppe_pkg::PIX_W-1:0]  wbyte;

    logic                        vld_reg, vld_next;
    logic [AW-1:0]               addr_reg;
    logic [cppe_pkg::PIX_W-1:0]  byte_reg;
    logic [AW-1:0]               lump_reg;
    logic                        last_reg, done_reg;

    assign busy      = (rem_reg != '0);
    assign out_free  = !vld_reg || m_tready;
    assign emit      = busy && out_free;
    assign rem_after = rem_reg & (rem_reg - 1'b1);
    assign last      = (rem_after == '0);
    assign take      = !busy || (emit && last);
    assign q_pop     = take && q_valid;
    assign ph        = cppe_pkg::low_index(rem_reg);

    always_comb begin
        rem_next = rem_reg;
        if (q_pop) begin
            rem_next = q_rdata.ph_en;
        end else if (emit) begin
            rem_next = rem_after;
        end
    end

    // byte positions after the column entry, relative to the item's base position
    always_comb begin
        c1_o      = 3'(cur_reg.ph_en[cppe_pkg::PH_C1_POS]);
        run_o     = c1_o + 3'(cur_reg.ph_en[cppe_pkg::PH_PIX])
                  + (cur_reg.ph_en[cppe_pkg::PH_OPEN_ROW] ? 3'd4 : 3'd0);
        end_o     = run_o + 3'(cur_reg.ph_en[cppe_pkg::PH_C2_POS]);
        slot_base = AW'({cur_reg.col, 2'b00}) + AW'(cppe_pkg::HDR_BYTES);
    end

    always_comb begin
        base  = cur_reg.wp_base;
        ofs   = '0;
        wbyte = '0;
        unique case (ph)
            cppe_pkg::PH_W_LO, cppe_pkg::PH_W_HI, cppe_pkg::PH_H_LO, cppe_pkg::PH_H_HI,
            cppe_pkg::PH_L_LO, cppe_pkg::PH_L_HI, cppe_pkg::PH_T_LO,
            cppe_pkg::PH_T_HI: begin
                // header slot code is the header byte address
                base = '0;
                ofs  = ph[2:0];
                unique case (ph)
                    cppe_pkg::PH_W_LO: wbyte = cfg.width[7:0];
                    cppe_pkg::PH_W_HI: wbyte = 8'(cfg.width[cppe_pkg::DIM_W-1:8]);
                    cppe_pkg::PH_H_LO: wbyte = cfg.height[7:0];
                    cppe_pkg::PH_H_HI: wbyte = 8'(cfg.height[cppe_pkg::DIM_W-1:8]);
                    cppe_pkg::PH_L_LO: wbyte = cfg.left[7:0];
                    cppe_pkg::PH_L_HI: wbyte = cfg.left[15:8];
                    cppe_pkg::PH_T_LO: wbyte = cfg.top[7:0];
                    default:           wbyte = cfg.top[15:8];
                endcase
            end
            cppe_pkg::PH_OFF_B0: begin
                base  = slot_base;
                wbyte = cur_reg.wp_base[7:0];
            end
            cppe_pkg::PH_OFF_B1: begin
                base  = slot_base;
                ofs   = 3'd1;
                wbyte = cur_reg.wp_base[15:8];
            end
            cppe_pkg::PH_OFF_B2: begin
                base  = slot_base;
                ofs   = 3'd2;
                wbyte = 8'(cur_reg.wp_base[AW-1:16]);
            end
            cppe_pkg::PH_OFF_B3: begin
                base  = slot_base;
                ofs   = 3'd3;
                wbyte = '0;
            end
            cppe_pkg::PH_C1_POS: begin
                wbyte = cur_reg.c1_val;
            end
            cppe_pkg::PH_C1_LEN: begin
                base  = cur_reg.c1_slot;
                wbyte = cur_reg.c1_len;
            end
            cppe_pkg::PH_PIX: begin
                ofs   = c1_o;
                wbyte = cur_reg.px;
            end
            cppe_pkg::PH_OPEN_ROW: begin
                ofs   = c1_o;
                wbyte = cur_reg.row_lo;
            end
            cppe_pkg::PH_OPEN_PX0: begin
                ofs   = c1_o + 3'd2;
                wbyte = cur_reg.px;
            end
            cppe_pkg::PH_OPEN_PX1: begin
                ofs   = c1_o + 3'd3;
                wbyte = cur_reg.px;
            end
            cppe_pkg::PH_C2_POS: begin
                ofs   = run_o;
                wbyte = cur_reg.px;
            end
            cppe_pkg::PH_C2_LEN: begin
                base  = cur_reg.c2_slot;
                wbyte = cur_reg.c2_len;
            end
            cppe_pkg::PH_COL_END: begin
                ofs   = end_o;
                wbyte = cppe_pkg::COL_END_BYTE;
            end
            default: begin
                base  = cur_reg.wp_base;
                wbyte = '0;
            end
        endcase
        addr = base + AW'(ofs);
    end

    always_comb begin
        vld_next = vld_reg;
        if (emit) begin
            vld_next = 1'b1;
        end else if (m_tready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            vld_reg <= 1'b0;
        end else begin
            rem_reg <= rem_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_rdata;
        end
        if (emit) begin
            addr_reg <= addr;
            byte_reg <= wbyte;
            lump_reg <= cur_reg.lump;
            last_reg <= last;
            done_reg <= last && cur_reg.done;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {lump_reg, byte_reg, addr_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = done_reg;

endmodule

[hdl/column_post_patch_encoder.sv]
// Column post picture encoder: pixels in, byte writes of the picture out.
// Throughput: one byte write per cycle on m_tdata unless stalled; a pixel takes one write in a
// run, up to 18 at picture start; the front takes one item per cycle while the queue has room.
// Reset (aresetn low, synchronous): counters, run state, queue and output cleared;
// width and height 1, offsets 0.
module column_post_patch_encoder #(
    parameter int unsigned MAX_WIDTH  = cppe_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = cppe_pkg::DEF_MAX_HEIGHT,
    parameter int unsigned MAX_RUN    = cppe_pkg::DEF_MAX_RUN
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] pixel_value
    input  logic                            s_tuser,   // [0] opaque
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [47:0]                     m_tdata,   // [19:0] write_addr, [27:20] write_byte,
                                                       // [47:28] lump_length
    output logic                            m_tlast,   // last_of_item
    output logic                            m_tuser,   // [0] image_done
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cppe_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cppe_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cppe_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    cppe_pkg::cfg_t  cfg;
    cppe_pkg::desc_t q_wdata, q_rdata;
    logic            q_push, q_full, q_pop, q_valid;

    cppe_regs #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_regs (
        .aclk   (aclk),
        .aresetn(aresetn),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .cfg    (cfg)
    );

    cppe_front #(
        .MAX_RUN(MAX_RUN)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    cppe_queue u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (q_push),
        .wdata  (q_wdata),
        .full   (q_full),
        .pop    (q_pop),
        .rvalid (q_valid),
        .rdata  (q_rdata)
    );

    cppe_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_rdata (q_rdata),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

endmodule

[hdl/cppe_checker.sv]
// Port-level checks for the encoder, bound to the top level.
module cppe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    logic        mid_reg, mid_next;
    logic [19:0] lump_reg, lump_next;
    logic        m_acc;

    assign m_acc = m_tvalid && m_tready;

    // remember the byte count seen on the item so far
    always_comb begin
        mid_next  = mid_reg;
        lump_next = lump_reg;
        if (m_acc) begin
            mid_next  = !m_tlast;
            lump_next = m_tdata[47:28];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg  <= 1'b0;
            lump_reg <= '0;
        end else begin
            mid_reg  <= mid_next;
            lump_reg <= lump_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result item changed while stalled");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("picture end flagged on a write that is not the last of its item");

    a_lump_same: assert property (@(posedge aclk) disable iff (!aresetn)
        m_acc && mid_reg |-> m_tdata[47:28] == lump_reg)
        else $error("byte count differs between writes of one item");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind column_post_patch_encoder cppe_checker u_cppe_checker (.*);

[tb/column_post_checker.sv]
// Checker for the column post encoder: snoops both streams and the register port, predicts writes.
module column_post_checker
    import cppe_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] pixel_value
    input  logic                  s_tuser,   // [0] opaque
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [47:0]           m_tdata,   // [19:0] write_addr, [27:20] write_byte,
                                             // [47:28] lump_length
    input  logic                  m_tlast,   // last_of_item
    input  logic                  m_tuser,   // [0] image_done
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int unsigned           fail_count,
    output int unsigned           pending,
    output int unsigned           writes_checked,
    output int unsigned           pictures_done
);

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
        logic              last;
        logic              done;
        logic [ADDR_W-1:0] lump;
    } byte_write_t;

    byte_write_t expected_writes[$];
    byte_write_t pixel_writes[$];

    // register copies
    logic [DIM_W-1:0] cfg_width;
    logic [DIM_W-1:0] cfg_height;
    logic [OFS_W-1:0] cfg_left;
    logic [OFS_W-1:0] cfg_top;

    // encoder state
    int unsigned       row_no;
    int unsigned       col_no;
    logic [ADDR_W-1:0] wpos;
    bit                in_run;
    int unsigned       run_len;
    logic [ADDR_W-1:0] len_slot;
    logic [PIX_W-1:0]  run_tail;

    initial begin
        fail_count     = 0;
        pending        = 0;
        writes_checked = 0;
        pictures_done  = 0;
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < 40) $display("%0t checker: %s", $time, msg);
        fail_count++;
    endtask

    function automatic int unsigned fit_dim(input logic [DIM_W-1:0] v, input int unsigned limit);
        if (v == '0) return 1;
        if (v > limit) return limit;
        return 32'(v);
    endfunction

    task automatic put(input int unsigned addr, input int unsigned data);
        byte_write_t wr;
        wr      = '0;
        wr.addr = ADDR_W'(addr);
        wr.data = PIX_W'(data);
        pixel_writes.push_back(wr);
    endtask

    task automatic put_next(input int unsigned data);
        put(32'(wpos), data);
        wpos = wpos + 1'b1;
    endtask

    task automatic close_run();
        put_next(32'(run_tail));
        put(32'(len_slot), run_len);
        in_run  = 1'b0;
        run_len = 0;
    endtask

    task automatic encode_pixel(input logic [PIX_W-1:0] px, input logic opaque);
        int unsigned w;
        int unsigned h;
        int unsigned slot;
        bit          picture_end;
        byte_write_t wr;
        w = fit_dim(cfg_width, DEF_MAX_WIDTH);
        h = fit_dim(cfg_height, DEF_MAX_HEIGHT);
        picture_end = 1'b0;
        pixel_writes.delete();

        if (row_no == 0 && col_no == 0) begin
            wpos = ADDR_W'(HDR_BYTES + 4 * w);
            put(0, w);
            put(1, w >> 8);
            put(2, h);
            put(3, h >> 8);
            put(4, 32'(cfg_left));
            put(5, 32'(cfg_left >> 8));
            put(6, 32'(cfg_top));
            put(7, 32'(cfg_top >> 8));
        end
        if (row_no == 0) begin
            slot = HDR_BYTES + 4 * col_no;
            put(slot, 32'(wpos));
            put(slot + 1, 32'(wpos >> 8));
            put(slot + 2, 32'(wpos >> 16));
            put(slot + 3, 0);
        end

        if (opaque) begin
            // a full run is closed and a new one opened at this row
            if (in_run && run_len >= DEF_MAX_RUN) close_run();
            if (in_run) begin
                put_next(32'(px));
                run_len++;
            end else begin
                put(32'(wpos), row_no);
                len_slot = wpos + 1'b1;
                put(32'(wpos) + 2, 32'(px));
                put(32'(wpos) + 3, 32'(px));
                wpos    = wpos + 3'd4;
                in_run  = 1'b1;
                run_len = 1;
            end
            run_tail = px;
        end else if (in_run) begin
            close_run();
        end

        if (row_no + 1 >= h) begin
            if (in_run) close_run();
            put_next(32'(COL_END_BYTE));
            row_no = 0;
            col_no++;
            if (col_no >= w) begin
                col_no      = 0;
                picture_end = 1'b1;
                pictures_done++;
            end
        end else begin
            row_no++;
        end

        for (int k = 0; k < pixel_writes.size(); k++) begin
            wr      = pixel_writes[k];
            wr.last = (k == pixel_writes.size() - 1);
            wr.done = wr.last && picture_end;
            wr.lump = wpos;
            expected_writes.push_back(wr);
        end
    endtask

    task automatic check_write();
        byte_write_t want;
        if (expected_writes.size() == 0) begin
            report_mismatch($sformatf("write to %h with nothing expected", m_tdata[19:0]));
            return;
        end
        want = expected_writes.pop_front();
        writes_checked++;
        if (m_tdata[19:0] !== want.addr)
            report_mismatch($sformatf("write_addr %h, want %h", m_tdata[19:0], want.addr));
        if (m_tdata[27:20] !== want.data)
            report_mismatch($sformatf("write_byte %h at %h, want %h",
                                      m_tdata[27:20], want.addr, want.data));
        if (m_tdata[47:28] !== want.lump)
            report_mismatch($sformatf("lump_length %h at %h, want %h",
                                      m_tdata[47:28], want.addr, want.lump));
        if (m_tlast !== want.last)
            report_mismatch($sformatf("last_of_item %b at %h, want %b",
                                      m_tlast, want.addr, want.last));
        if (m_tuser !== want.done)
            report_mismatch($sformatf("image_done %b at %h, want %b",
                                      m_tuser, want.addr, want.done));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width  = DIM_W'(1);
            cfg_height = DIM_W'(1);
            cfg_left   = '0;
            cfg_top    = '0;
            row_no     = 0;
            col_no     = 0;
            wpos       = '0;
            in_run     = 1'b0;
            run_len    = 0;
            len_slot   = '0;
            run_tail   = '0;
            expected_writes.delete();
        end else begin
            if (m_tvalid && m_tready) check_write();
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_WIDTH:  cfg_width  = pwdata[DIM_W-1:0];
                    REG_HEIGHT: cfg_height = pwdata[DIM_W-1:0];
                    REG_LEFT:   cfg_left   = pwdata[OFS_W-1:0];
                    REG_TOP:    cfg_top    = pwdata[OFS_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) encode_pixel(s_tdata, s_tuser);
        end
        pending = expected_writes.size();
    end

endmodule

[tb/tb_top.sv]
// Top of the column post encoder bench: clock, reset, register setup, pixel stimulus, verdict.
module tb_top;
    import cppe_pkg::*;

    localparam int unsigned IDLE_LIMIT = 2000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [47:0]           m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned stall_cycles;
    int unsigned pixels_sent;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned writes_checked;
    int unsigned pictures_done;
    int unsigned cur_w;
    int unsigned cur_h;

    column_post_patch_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    column_post_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .fail_count     (fail_count),
        .pending        (pending),
        .writes_checked (writes_checked),
        .pictures_done  (pictures_done)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // no item moving on any port for too long means the block has hung
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= IDLE_LIMIT) begin
            $display("tb_top: no progress for %0d cycles", IDLE_LIMIT);
            $display("tb_top: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_pixel(input logic [7:0] value, input logic opaque);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= opaque;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pixels_sent++;
    endtask

    // random pixels with opacity in runs; long stretches keep posts open
    task automatic send_pixels(input int unsigned count, input int unsigned flip_pct);
        logic opq;
        opq = 1'($urandom_range(1));
        for (int unsigned i = 0; i < count; i++) begin
            if ($urandom_range(99) < flip_pct) opq = ~opq;
            send_pixel(8'($urandom_range(255)), opq);
        end
    endtask

    // hold back until every write is out, then give the pipeline time to settle
    task automatic drain_writes();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_picture(input logic [31:0] w, input logic [31:0] h,
                               input logic [31:0] l, input logic [31:0] t);
        drain_writes();
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        reg_write(REG_LEFT, l);
        reg_write(REG_TOP, t);
    endtask

    initial begin
        int unsigned w_reg;
        int unsigned h_reg;
        int unsigned total;
        int unsigned count;
        int unsigned mark;
        int unsigned sel;

        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        m_tready     = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        pixels_sent  = 0;
        src_idle_pct = 14;
        snk_idle_pct = 70;
        cur_w        = 1;
        cur_h        = 1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset size: one-pixel pictures, opaque then transparent
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hff, 1'b0);

        // 3x4: run closed by a gap, run closed by column end, empty column, full column
        set_picture(3, 4, 32'h0000_8000, 32'h0000_7fff);
        send_pixel(8'hff, 1'b1);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'h5a, 1'b0);
        send_pixel(8'ha5, 1'b1);
        repeat (4) send_pixel(8'($urandom_range(255)), 1'b0);
        repeat (4) send_pixel(8'($urandom_range(255)), 1'b1);

        // oversized width and zero height, then the width shrinks under a part-built picture
        set_picture(511, 0, 32'h0000_7fff, 32'h0000_8000);
        repeat (3) send_pixel(8'($urandom_range(255)), 1'b1);
        drain_writes();
        reg_write(REG_WIDTH, 2);
        send_pixel(8'h81, 1'b1);

        // height shrinks in the middle of an open post
        set_picture(1, 8, 0, 0);
        repeat (3) send_pixel(8'($urandom_range(255)), 1'b1);
        drain_writes();
        reg_write(REG_HEIGHT, 2);
        send_pixel(8'h7e, 1'b1);

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    src_idle_pct = 14;
                    snk_idle_pct = 70;
                end
                1: begin
                    src_idle_pct = 70;
                    snk_idle_pct = 14;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            mark = pixels_sent;
            while (pixels_sent < mark + 55) begin
                if ($urandom_range(99) < 60) begin
                    cur_w = $urandom_range(1, 5);
                    w_reg = cur_w;
                    sel   = $urandom_range(9);
                    if (sel == 0) begin
                        cur_w = 1;
                        w_reg = 0;
                    end else if (sel == 1) begin
                        cur_w = 256;
                        w_reg = $urandom_range(256, 511);
                    end
                    cur_h = $urandom_range(1, 12);
                    h_reg = cur_h;
                    sel   = $urandom_range(9);
                    if (sel == 0) begin
                        cur_h = 1;
                        h_reg = 0;
                    end else if (sel == 1) begin
                        cur_h = 256;
                        h_reg = $urandom_range(256, 511);
                    end
                    // junk above each register's width must be ignored
                    set_picture(w_reg | ($urandom << DIM_W), h_reg | ($urandom << DIM_W),
                                $urandom, $urandom);
                end
                total = cur_w * cur_h;
                count = total;
                if (total > 40 || $urandom_range(5) == 0)
                    count = $urandom_range(1, (total < 24) ? total : 24);
                send_pixels(count, $urandom_range(10, 50));
            end
        end

        drain_writes();
        repeat (12) @(posedge aclk);
        $display("tb_top: %0d pixels in, %0d byte writes checked, %0d pictures closed",
                 pixels_sent, writes_checked, pictures_done);
        $display("tb_top: header extremes, posts closed by gaps and column ends, resizing");
        $display("tb_top: mid-picture, three stall mixes");
        if (fail_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

[column_post_patch_encoder.f]
hdl/cppe_pkg.sv
hdl/cppe_regs.sv
hdl/cppe_front.sv
hdl/cppe_queue.sv
hdl/cppe_back.sv
hdl/column_post_patch_encoder.sv
hdl/cppe_checker.sv
tb/column_post_checker.sv
tb/tb_top.sv
